// ----- hw/rtl/ffpc_pkg.sv -----
// ffpc_pkg: shared constants, types and helper functions for the flat-field
// pixel correction unit; no dependencies
`default_nettype none

package ffpc_pkg;

	// fixed-point format
	localparam int FRAC_BITS = 16;
	localparam int REF_W     = 17;
	localparam int VAL_W     = 20;
	localparam int QBITS     = 24;
	localparam int DVD_W     = 36;
	localparam int DVS_W     = 26;
	localparam int NCELLS    = QBITS;

	localparam logic [REF_W-1:0] ONE = REF_W'(1) << FRAC_BITS;
	localparam logic signed [VAL_W-1:0] OUT_MAX = VAL_W'(524287);
	localparam logic signed [VAL_W-1:0] OUT_MIN = VAL_W'(-524288);

	// register select values for paddr[2], which decodes the two registers
	localparam logic ADDR_LUMA   = 1'b0;
	localparam logic ADDR_CHROMA = 1'b1;

	// state of one restoring division in flight
	typedef struct packed {
		logic [DVS_W-1:0] rem;
		logic [QBITS-1:0] low;
		logic [DVS_W-1:0] dvs;
		logic [QBITS-1:0] quo;
	} div_t;

	// item context carried alongside a division chain
	typedef struct packed {
		logic signed [VAL_W-1:0] v;
		logic                    skip;
		logic                    dzero;
		logic                    ovf;
		logic                    neg;
		logic                    sat;
		logic                    green;
		logic                    g0;
		logic                    rovf;
	} ctx_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] val;
		logic                    sat;
	} res_t;

	// set up a division: high dividend bits seed the remainder
	function automatic div_t div_init(input logic [DVD_W-1:0] dvd,
		input logic [DVS_W-1:0] dvs);
		div_t d;
		d.rem = DVS_W'(dvd[DVD_W-1:QBITS]);
		d.low = dvd[QBITS-1:0];
		d.dvs = dvs;
		d.quo = '0;
		return d;
	endfunction

	// turn a finished quotient into a clamped signed sample
	function automatic res_t resolve(input logic skip, input logic signed [VAL_W-1:0] x,
		input logic dzero, input logic ovf, input logic neg,
		input logic [QBITS-1:0] quo);
		res_t r;
		logic signed [QBITS:0] q;
		q = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		r.sat = 1'b0;
		r.val = x;
		if (skip) begin
			r.val = x;
		end else if (dzero) begin
			r.sat = 1'b1;
			if (x > 0)
				r.val = OUT_MAX;
			else if (x < 0)
				r.val = OUT_MIN;
			else
				r.val = '0;
		end else if (ovf) begin
			r.sat = 1'b1;
			r.val = neg ? OUT_MIN : OUT_MAX;
		end else if (q > (QBITS+1)'(OUT_MAX)) begin
			r.sat = 1'b1;
			r.val = OUT_MAX;
		end else if (q < (QBITS+1)'(OUT_MIN)) begin
			r.sat = 1'b1;
			r.val = OUT_MIN;
		end else begin
			r.val = q[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ffpc_div_cell.sv -----
// ffpc_div_cell: one restoring division step, one quotient bit per cell
// depends on ffpc_pkg
`default_nettype none

module ffpc_div_cell (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire ffpc_pkg::div_t d_in,
	output ffpc_pkg::div_t      d_out
);

	logic [ffpc_pkg::DVS_W:0]   rem2;
	logic                       ge;
	ffpc_pkg::div_t             d_nxt;

	// shift in next dividend bit, trial subtract
	always_comb begin
		rem2  = {d_in.rem, d_in.low[ffpc_pkg::QBITS-1]};
		ge    = rem2 >= {1'b0, d_in.dvs};
		d_nxt = d_in;
		d_nxt.rem = ge ? ffpc_pkg::DVS_W'(rem2 - {1'b0, d_in.dvs})
		               : rem2[ffpc_pkg::DVS_W-1:0];
		d_nxt.low = d_in.low << 1;
		d_nxt.quo = {d_in.quo[ffpc_pkg::QBITS-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en)
			d_out <= d_nxt;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/ffpc_div_chain.sv -----
// ffpc_div_chain: row of division cells with the item context shifted alongside
// depends on ffpc_pkg and ffpc_div_cell
`default_nettype none

module ffpc_div_chain (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           vld_in,
	input  wire ffpc_pkg::ctx_t ctx_in,
	input  wire ffpc_pkg::div_t div_in,
	output logic                vld_out,
	output ffpc_pkg::ctx_t      ctx_out,
	output ffpc_pkg::div_t      div_out
);

	ffpc_pkg::div_t stage [ffpc_pkg::NCELLS];
	ffpc_pkg::ctx_t ctx_q [ffpc_pkg::NCELLS];
	logic [ffpc_pkg::NCELLS-1:0] vld_q;

	// the cells
	for (genvar i = 0; i < ffpc_pkg::NCELLS; i++) begin : g_cell
		if (i == 0) begin : g_first
			ffpc_div_cell u_cell (.clk(clk), .en(en), .d_in(div_in), .d_out(stage[i]));
		end else begin : g_next
			ffpc_div_cell u_cell (.clk(clk), .en(en), .d_in(stage[i-1]), .d_out(stage[i]));
		end
	end

	// context travels in step with the cells
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q[0] <= ctx_in;
			for (int i = 1; i < ffpc_pkg::NCELLS; i++)
				ctx_q[i] <= ctx_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[ffpc_pkg::NCELLS-2:0], vld_in};
		end
	end

	assign vld_out = vld_q[ffpc_pkg::NCELLS-1];
	assign ctx_out = ctx_q[ffpc_pkg::NCELLS-1];
	assign div_out = stage[ffpc_pkg::NCELLS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/flat_field_pixel_correct_unit.sv -----
// flat_field_pixel_correct_unit: top level, APB registers, setup stages and
// three division chains; depends on ffpc_pkg and ffpc_div_chain
//
// channel   | handshake                  | payload
// pixel     | pixel_valid / pixel_ready  | pixel_value, green_reference, own_reference,
//           |                            | is_green_site
// result    | result_valid / result_ready| corrected_value, saturated
// config    | psel penable pwrite pready | paddr, pwdata, prdata
//
// one pixel per clock while no result stalls; each pixel passes through
// 54 register stages, two rows of 24 division cells (one quotient bit per cell)
// plus five setup stages and the output register
// reset clears the valid bits and both strengths to zero
// a stalled result holds the whole pipeline; pixel_ready drops only then
`default_nettype none

module flat_field_pixel_correct_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// pixel channel
	input  wire logic                pixel_valid,
	output logic                     pixel_ready,
	input  wire logic signed [16:0]  pixel_value,
	input  wire logic [16:0]         green_reference,
	input  wire logic [16:0]         own_reference,
	input  wire logic                is_green_site,
	// result channel
	output logic                     result_valid,
	input  wire logic                result_ready,
	output logic signed [19:0]       corrected_value,
	output logic                     saturated,
	// configuration port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	localparam int RW = ffpc_pkg::REF_W;
	localparam int VW = ffpc_pkg::VAL_W;

	logic [RW-1:0] luma_q, chroma_q;
	logic          en;

	// register writes and reads
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_q   <= '0;
			chroma_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				ffpc_pkg::ADDR_LUMA:   luma_q   <= pwdata[RW-1:0];
				ffpc_pkg::ADDR_CHROMA: chroma_q <= pwdata[RW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ffpc_pkg::ADDR_LUMA:   prdata = 32'(luma_q);
			ffpc_pkg::ADDR_CHROMA: prdata = 32'(chroma_q);
			default:               prdata = '0;
		endcase
	end

	// global advance
	assign en          = !result_valid || result_ready;
	assign pixel_ready = en;

	// stage 1: capture transaction, green reference times luma strength
	localparam int FRAC = ffpc_pkg::FRAC_BITS;
	logic                     vld_s1;
	logic signed [16:0]       v_s1;
	logic [RW-1:0]            g_s1, r_s1;
	logic                     green_s1;
	logic [2*RW-FRAC-1:0]     gl_s1;
	logic [2*RW-1:0]          gl_full;

	// full-width product, floor back to the fraction format
	assign gl_full = green_reference * luma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= pixel_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1     <= pixel_value;
			g_s1     <= green_reference;
			r_s1     <= own_reference;
			green_s1 <= is_green_site;
			gl_s1    <= gl_full[2*RW-1:FRAC];
		end
	end

	// stage 2: divisor one, magnitudes, range precheck for both divisions
	logic signed [20:0]             d1;
	logic [19:0]                    d1_mag;
	logic [16:0]                    v_mag;
	logic [ffpc_pkg::DVD_W-1:0]     dvd1, dvdr;
	logic [ffpc_pkg::DVS_W-1:0]     dvs1, dvsr;
	ffpc_pkg::ctx_t                 ctx1_in;
	ffpc_pkg::div_t                 div1_in, divr_in;
	logic                           vld2_s2;
	ffpc_pkg::ctx_t                 ctx_s2;
	ffpc_pkg::div_t                 div1_s2, divr_s2;

	always_comb begin
		d1     = 21'(ffpc_pkg::ONE) - $signed({4'b0, luma_q}) + $signed({3'b0, gl_s1});
		d1_mag = d1[20] ? 20'(-d1) : 20'(d1);
		v_mag  = v_s1[16] ? 17'(-v_s1) : 17'(v_s1);
		dvd1   = ffpc_pkg::DVD_W'({v_mag, {FRAC{1'b0}}});
		dvs1   = ffpc_pkg::DVS_W'(d1_mag);
		dvdr   = ffpc_pkg::DVD_W'({r_s1, {FRAC{1'b0}}});
		dvsr   = ffpc_pkg::DVS_W'(g_s1);
		div1_in = ffpc_pkg::div_init(dvd1, dvs1);
		divr_in = ffpc_pkg::div_init(dvdr, dvsr);
		ctx1_in.v     = VW'(v_s1);
		ctx1_in.skip  = luma_q == '0;
		ctx1_in.dzero = d1 == '0;
		ctx1_in.ovf   = ffpc_pkg::DVS_W'(dvd1[ffpc_pkg::DVD_W-1:ffpc_pkg::QBITS]) >= dvs1;
		ctx1_in.neg   = v_s1[16] ^ d1[20];
		ctx1_in.sat   = 1'b0;
		ctx1_in.green = green_s1;
		ctx1_in.g0    = g_s1 == '0;
		ctx1_in.rovf  = ffpc_pkg::DVS_W'(dvdr[ffpc_pkg::DVD_W-1:ffpc_pkg::QBITS]) >= dvsr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld2_s2 <= 1'b0;
		else if (en)
			vld2_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2  <= ctx1_in;
			div1_s2 <= div1_in;
			divr_s2 <= divr_in;
		end
	end

	// luminance division and reference ratio run side by side
	logic           vld_c1;
	ffpc_pkg::ctx_t ctx_c1;
	ffpc_pkg::div_t div_c1, divr_c1;

	ffpc_div_chain u_chain_luma (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld2_s2), .ctx_in(ctx_s2), .div_in(div1_s2),
		.vld_out(vld_c1), .ctx_out(ctx_c1), .div_out(div_c1)
	);

	ffpc_div_chain u_chain_ratio (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld2_s2), .ctx_in('0), .div_in(divr_s2),
		.vld_out(), .ctx_out(), .div_out(divr_c1)
	);

	// stage 3: luminance result and clamped ratio
	ffpc_pkg::res_t                 res1;
	logic                           vld_s3;
	logic signed [VW-1:0]           v1_s3;
	logic                           sat_s3, green_s3, g0_s3;
	logic [ffpc_pkg::QBITS-1:0]     ratio_s3;

	assign res1 = ffpc_pkg::resolve(ctx_c1.skip, ctx_c1.v, ctx_c1.dzero, ctx_c1.ovf,
		ctx_c1.neg, div_c1.quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= vld_c1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v1_s3    <= res1.val;
			sat_s3   <= res1.sat;
			green_s3 <= ctx_c1.green;
			g0_s3    <= ctx_c1.g0;
			ratio_s3 <= (ctx_c1.g0 || ctx_c1.rovf) ? '1 : divr_c1.quo;
		end
	end

	// stage 4: ratio times chroma strength
	localparam int RC_W = ffpc_pkg::QBITS + RW - FRAC;
	logic                 vld_s4;
	logic signed [VW-1:0] v1_s4;
	logic                 sat_s4, green_s4, g0_s4;
	logic [RC_W-1:0]      rc_s4;
	logic [ffpc_pkg::QBITS+RW-1:0] rc_full;

	// full-width product, floor back to the fraction format
	assign rc_full = ratio_s3 * chroma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v1_s4    <= v1_s3;
			sat_s4   <= sat_s3;
			green_s4 <= green_s3;
			g0_s4    <= g0_s3;
			rc_s4    <= rc_full[ffpc_pkg::QBITS+RW-1:FRAC];
		end
	end

	// stage 5: divisor two, magnitudes, precheck
	logic signed [RC_W+1:0]         d2;
	logic [ffpc_pkg::DVS_W-1:0]     dvs2;
	logic [VW-1:0]                  v1_mag;
	logic [ffpc_pkg::DVD_W-1:0]     dvd2;
	ffpc_pkg::ctx_t                 ctx2_in;
	ffpc_pkg::div_t                 div2_in;
	logic                           vld_s5;
	ffpc_pkg::ctx_t                 ctx_s5;
	ffpc_pkg::div_t                 div2_s5;

	always_comb begin
		d2     = (RC_W+2)'(ffpc_pkg::ONE) - $signed((RC_W+2)'(chroma_q))
		       + $signed((RC_W+2)'(rc_s4));
		dvs2   = d2[RC_W+1] ? ffpc_pkg::DVS_W'(-d2) : ffpc_pkg::DVS_W'(d2);
		v1_mag = v1_s4[VW-1] ? VW'(-v1_s4) : VW'(v1_s4);
		dvd2   = ffpc_pkg::DVD_W'({v1_mag, {FRAC{1'b0}}});
		div2_in = ffpc_pkg::div_init(dvd2, dvs2);
		ctx2_in.v     = v1_s4;
		ctx2_in.skip  = green_s4 || chroma_q == '0;
		ctx2_in.dzero = d2 == '0;
		ctx2_in.ovf   = ffpc_pkg::DVS_W'(dvd2[ffpc_pkg::DVD_W-1:ffpc_pkg::QBITS]) >= dvs2;
		ctx2_in.neg   = v1_s4[VW-1] ^ d2[RC_W+1];
		ctx2_in.sat   = sat_s4 || (g0_s4 && !(green_s4 || chroma_q == '0));
		ctx2_in.green = green_s4;
		ctx2_in.g0    = g0_s4;
		ctx2_in.rovf  = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else if (en)
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5  <= ctx2_in;
			div2_s5 <= div2_in;
		end
	end

	// colour division
	logic           vld_c2;
	ffpc_pkg::ctx_t ctx_c2;
	ffpc_pkg::div_t div_c2;

	ffpc_div_chain u_chain_chroma (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_s5), .ctx_in(ctx_s5), .div_in(div2_s5),
		.vld_out(vld_c2), .ctx_out(ctx_c2), .div_out(div_c2)
	);

	// output register
	ffpc_pkg::res_t res2;

	assign res2 = ffpc_pkg::resolve(ctx_c2.skip, ctx_c2.v, ctx_c2.dzero, ctx_c2.ovf,
		ctx_c2.neg, div_c2.quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (en)
			result_valid <= vld_c2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corrected_value <= res2.val;
			saturated       <= res2.sat || ctx_c2.sat;
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb_flat_field_pixel_correct_unit.sv -----
// tb_flat_field_pixel_correct_unit: self-checking testbench for the flat-field
// pixel correction unit; depends on ffpc_pkg and flat_field_pixel_correct_unit
`default_nettype none

module tb_flat_field_pixel_correct_unit;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_LUMA   = {ffpc_pkg::ADDR_LUMA, 2'b00};
	localparam logic [2:0] REG_CHROMA = {ffpc_pkg::ADDR_CHROMA, 2'b00};
	localparam longint UNITY     = 64'd1 << ffpc_pkg::FRAC_BITS;
	localparam longint RATIO_MAX = (64'd1 << (8 + ffpc_pkg::FRAC_BITS)) - 1;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 70;

	typedef struct packed {
		logic signed [16:0] value;
		logic [16:0]        green_ref;
		logic [16:0]        own_ref;
		logic               green;
	} pixel_t;

	typedef struct packed {
		logic signed [19:0] value;
		logic               sat;
	} corrected_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pixel_valid = 1'b0;
	logic pixel_ready;
	logic signed [16:0] pixel_value = '0;
	logic [16:0] green_reference = '0;
	logic [16:0] own_reference = '0;
	logic is_green_site = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [19:0] corrected_value;
	logic saturated;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	flat_field_pixel_correct_unit dut (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
		.pixel_value(pixel_value), .green_reference(green_reference),
		.own_reference(own_reference), .is_green_site(is_green_site),
		.result_valid(result_valid), .result_ready(result_ready),
		.corrected_value(corrected_value), .saturated(saturated),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// local copy of the strength registers
	logic [16:0] luma_cfg = '0;
	logic [16:0] chroma_cfg = '0;

	pixel_t     pending_pixels[$];
	corrected_t expected_samples[$];
	int mismatches = 0;
	int pixels_sent = 0;
	int samples_checked = 0;
	int sat_seen = 0;
	int cycles = 0;
	bit idle_enable = 1'b1;
	bit long_hold_req = 1'b0;
	bit pixel_fired = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_count = 0;

	// x * unity / d, truncated toward zero, clamped to 20 bits
	function automatic longint scaled_quotient(longint x, longint d, inout bit sat);
		longint q;
		if (d == 0) begin
			sat = 1'b1;
			return (x > 0) ? 524287 : (x < 0) ? -524288 : 0;
		end
		q = (x * UNITY) / d;
		if (q > 524287) begin
			sat = 1'b1;
			return 524287;
		end
		if (q < -524288) begin
			sat = 1'b1;
			return -524288;
		end
		return q;
	endfunction

	// luminance then colour correction of one sample
	function automatic corrected_t correct_pixel(pixel_t p, logic [16:0] luma,
		logic [16:0] chroma);
		corrected_t res;
		longint v, div, ratio;
		bit sat;
		sat = 1'b0;
		v = p.value;
		if (luma != 0) begin
			div = UNITY - longint'(luma)
				+ ((longint'(p.green_ref) * longint'(luma)) >>> ffpc_pkg::FRAC_BITS);
			v = scaled_quotient(v, div, sat);
		end
		if (!p.green && chroma != 0) begin
			if (p.green_ref == 0) begin
				ratio = RATIO_MAX;
				sat = 1'b1;
			end else begin
				ratio = (longint'(p.own_ref) << ffpc_pkg::FRAC_BITS)
					/ longint'(p.green_ref);
				if (ratio > RATIO_MAX)
					ratio = RATIO_MAX;
			end
			div = UNITY - longint'(chroma)
				+ ((ratio * longint'(chroma)) >>> ffpc_pkg::FRAC_BITS);
			v = scaled_quotient(v, div, sat);
		end
		res.value = v[19:0];
		res.sat = sat;
		return res;
	endfunction

	// random sample with reference values biased toward the corners
	function automatic logic [16:0] pick_ref();
		case ($urandom_range(0, 9))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'($urandom);
			3: return 17'($urandom_range(1, 64));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		case ($urandom_range(0, 7))
			0: p.value = 17'sd65535;
			1: p.value = -17'sd65535;
			2: p.value = 17'($urandom_range(0, 15));
			default: p.value = 17'($urandom);
		endcase
		p.green_ref = pick_ref();
		p.own_ref = pick_ref();
		p.green = 1'($urandom_range(0, 1));
		return p;
	endfunction

	// two-phase register write, only while the pipe is empty
	task automatic write_reg(input logic [2:0] addr, input logic [16:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {15'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_LUMA)
			luma_cfg = val;
		else
			chroma_cfg = val;
	endtask

	task automatic queue_pixel(input logic signed [16:0] v, input logic [16:0] g,
		input logic [16:0] r, input logic green);
		pixel_t p;
		p.value = v;
		p.green_ref = g;
		p.own_ref = r;
		p.green = green;
		pending_pixels.push_back(p);
	endtask

	task automatic drain();
		while (pending_pixels.size() != 0 || pixel_valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// pixel driver: holds until accepted, random idle bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (pixel_valid && !pixel_fired) begin
				// keep offering the same transaction
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				pixel_valid <= 1'b0;
			end else if (pending_pixels.size() != 0
				&& !(idle_enable && $urandom_range(0, 9) == 0)) begin
				pixel_t p;
				p = pending_pixels.pop_front();
				pixel_valid <= 1'b1;
				pixel_value <= p.value;
				green_reference <= p.green_ref;
				own_reference <= p.own_ref;
				is_green_site <= p.green;
			end else begin
				pixel_valid <= 1'b0;
				if (idle_enable && pending_pixels.size() != 0)
					send_gap <= $urandom_range(0, 10);
			end
		end
	end

	// record accepted pixels and predict their corrected samples
	always @(posedge clk) begin
		pixel_fired <= pixel_valid && pixel_ready;
		if (arst_n && pixel_valid && pixel_ready) begin
			pixel_t p;
			p.value = pixel_value;
			p.green_ref = green_reference;
			p.own_ref = own_reference;
			p.green = is_green_site;
			expected_samples.push_back(correct_pixel(p, luma_cfg, chroma_cfg));
			pixels_sent++;
		end
	end

	// result ready: a long hold on request, else random stall bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (long_hold_req || hold_count > 0) begin
			result_ready <= 1'b0;
			if (hold_count == 0)
				hold_count <= 300;
			else
				hold_count <= hold_count - 1;
			if (hold_count == 1)
				long_hold_req <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			result_ready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 11) == 0) begin
			recv_gap <= $urandom_range(0, 10);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			corrected_t want;
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %0d sat %0b",
						corrected_value, saturated);
			end else begin
				want = expected_samples.pop_front();
				samples_checked++;
				if (want.sat)
					sat_seen++;
				if (corrected_value !== want.value || saturated !== want.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch at result %0d: value exp %0d got %0d,",
							" sat exp %0b got %0b"}, samples_checked, want.value,
							corrected_value, want.sat, saturated);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// stimulus: several strength settings, directed corners first
	initial begin
		logic [16:0] luma_set[8];
		logic [16:0] chroma_set[8];
		luma_set   = '{17'd65536, 17'd0, 17'd32768, 17'h1FFFF,
			17'd1, 17'd65536, 17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536))};
		chroma_set = '{17'd65536, 17'd0, 17'd16384, 17'h1FFFF,
			17'd65536, 17'd0, 17'($urandom_range(0, 65536)), 17'($urandom_range(1, 65536))};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_LUMA, luma_set[ph]);
			write_reg(REG_CHROMA, chroma_set[ph]);
			if (ph == 0) begin
				// zero luminance divisor: green reference zero at full strength
				queue_pixel(17'sd1000, 17'd0, 17'd100, 1'b1);
				queue_pixel(-17'sd1000, 17'd0, 17'd100, 1'b1);
				queue_pixel(17'sd0, 17'd0, 17'd100, 1'b1);
				// zero colour divisor: own reference zero
				queue_pixel(17'sd500, 17'd65536, 17'd0, 1'b0);
				queue_pixel(-17'sd500, 17'd65536, 17'd0, 1'b0);
				// zero green reference in the ratio
				queue_pixel(17'sd200, 17'd0, 17'd65536, 1'b0);
				// ratio above the Q8.16 range
				queue_pixel(17'sd65535, 17'd1, 17'd65536, 1'b0);
				// clamp on a small divisor
				queue_pixel(17'sd65535, 17'd1, 17'd1, 1'b1);
				queue_pixel(-17'sd65535, 17'd1, 17'd1, 1'b1);
				queue_pixel(-17'sd65536, 17'd2, 17'd3, 1'b0);
				// unity references leave the sample alone; then other reference mixes
				queue_pixel(17'sd65535, 17'd65536, 17'd65536, 1'b0);
				queue_pixel(-17'sd65535, 17'd65536, 17'd65536, 1'b1);
				queue_pixel(17'sd1234, 17'h1FFFF, 17'h1FFFF, 1'b0);
				queue_pixel(17'sd7, 17'd32768, 17'd49152, 1'b0);
				queue_pixel(-17'sd7, 17'd32768, 17'd16384, 1'b0);
				queue_pixel(17'sd0, 17'd12345, 17'd54321, 1'b0);
			end
			if (ph == 2)
				long_hold_req = 1'b1;
			if (ph == 7)
				idle_enable = 1'b0;
			for (int i = 0; i < 55; i++)
				pending_pixels.push_back(random_pixel());
			// sender pauses until everything has come back
			drain();
		end
		$display("covered %0d pixels over 8 strength settings, %0d results checked, %0d saturated",
			pixels_sent, samples_checked, sat_seen);
		if (mismatches == 0 && expected_samples.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
